@@ rtl/core/srxf_pkg.sv @@
// Shared constants, codes and types for the serial receive ring with realtime filter.
package srxf_pkg;

  localparam int RING_DEPTH = 128;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [7:0]       byte_t;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] REG_STATUS = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_HOLD   = 2'd2;
  localparam logic [1:0] REG_RESET  = 2'd3;

  localparam byte_t LINE_FEED        = 8'h0a;
  localparam byte_t STATUS_CHAR_INIT = 8'd63;
  localparam byte_t START_CHAR_INIT  = 8'd126;
  localparam byte_t HOLD_CHAR_INIT   = 8'd33;
  localparam byte_t RESET_CHAR_INIT  = 8'd24;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    byte_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } ring_req_t;

  typedef struct packed {
    logic read_valid;
    logic status_request;
    logic start_request;
    logic hold_request;
    logic reset_request;
    logic byte_dropped;
  } result_t;

endpackage

@@ rtl/core/serial_rx_fifo_realtime_filter_top.sv @@
// Top level of the serial receive ring with realtime character intercept.
//
// Input channel (in_valid, in_stall, in_op, in_rx_byte) carries one item per
// operation: a received byte, a read of the oldest stored byte, or a flush.
// Every item gives exactly one result item on the output channel
// (out_valid, out_stall and the result fields), in the cycle after acceptance.
// The result register holds the outcome; read data comes straight from the
// registered read port of the byte store, so it arrives with the result.
// Throughput is one item per cycle while the receiver takes results; the
// single result register sets that figure, and in_stall rises while a result
// is held by out_stall. A realtime byte raises its request flag instead of
// being stored, a line feed is dropped, and a byte that finds the ring full
// raises byte_dropped. The ring holds at most RING_DEPTH-1 bytes.
// The APB port writes the four realtime characters at byte addresses 0, 4, 8
// and 12; pready is always high. Reset empties the ring, restores the
// default characters and clears out_valid; the result fields and the byte
// store are not cleared, and the store needs no clearing pass.
module serial_rx_fifo_realtime_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_read_valid,
  output logic [7:0]                   out_read_data,
  output logic                         out_status_request,
  output logic                         out_start_request,
  output logic                         out_hold_request,
  output logic                         out_reset_request,
  output logic                         out_byte_dropped,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srxf_pkg::CFG_AW-1:0]  paddr,
  input  logic [srxf_pkg::CFG_DW-1:0]  pwdata,
  output logic [srxf_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import srxf_pkg::*;

  byte_t     status_char_r, start_char_r, hold_char_r, reset_char_r;
  idx_t      wr_idx_r, wr_idx_nxt;
  idx_t      rd_idx_r, rd_idx_nxt;
  idx_t      wr_inc, rd_inc;
  logic      out_valid_r, out_valid_nxt;
  result_t   res_r, res_nxt;
  ring_req_t ring_req;
  byte_t     ring_rdata;
  logic      accept;
  logic      cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_char_r <= STATUS_CHAR_INIT;
      start_char_r  <= START_CHAR_INIT;
      hold_char_r   <= HOLD_CHAR_INIT;
      reset_char_r  <= RESET_CHAR_INIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STATUS: status_char_r <= pwdata[7:0];
        REG_START:  start_char_r  <= pwdata[7:0];
        REG_HOLD:   hold_char_r   <= pwdata[7:0];
        REG_RESET:  reset_char_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STATUS: prdata = {(CFG_DW-8)'(0), status_char_r};
      REG_START:  prdata = {(CFG_DW-8)'(0), start_char_r};
      REG_HOLD:   prdata = {(CFG_DW-8)'(0), hold_char_r};
      REG_RESET:  prdata = {(CFG_DW-8)'(0), reset_char_r};
      default:    prdata = '0;
    endcase
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign wr_inc = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;

  always_comb begin
    wr_idx_nxt       = wr_idx_r;
    rd_idx_nxt       = rd_idx_r;
    res_nxt          = '0;
    ring_req.wr_en   = 1'b0;
    ring_req.wr_addr = wr_idx_r;
    ring_req.wr_data = in_rx_byte;
    ring_req.rd_en   = 1'b0;
    ring_req.rd_addr = rd_idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      case (in_op)
        OP_BYTE: begin
          if (in_rx_byte == LINE_FEED) begin
          end else if (in_rx_byte == status_char_r) begin
            res_nxt.status_request = 1'b1;
          end else if (in_rx_byte == start_char_r) begin
            res_nxt.start_request = 1'b1;
          end else if (in_rx_byte == hold_char_r) begin
            res_nxt.hold_request = 1'b1;
          end else if (in_rx_byte == reset_char_r) begin
            res_nxt.reset_request = 1'b1;
          end else if (wr_inc != rd_idx_r) begin
            ring_req.wr_en = 1'b1;
            wr_idx_nxt     = wr_inc;
          end else begin
            res_nxt.byte_dropped = 1'b1;
          end
        end
        OP_READ: begin
          if (wr_idx_r != rd_idx_r) begin
            ring_req.rd_en     = 1'b1;
            res_nxt.read_valid = 1'b1;
            rd_idx_nxt         = rd_inc;
          end
        end
        OP_FLUSH: begin
          rd_idx_nxt = wr_idx_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  srxf_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_read_valid     = res_r.read_valid;
  assign out_read_data      = res_r.read_valid ? ring_rdata : '0;
  assign out_status_request = res_r.status_request;
  assign out_start_request  = res_r.start_request;
  assign out_hold_request   = res_r.hold_request;
  assign out_reset_request  = res_r.reset_request;
  assign out_byte_dropped   = res_r.byte_dropped;

endmodule

@@ rtl/core/srxf_ring.sv @@
// Byte store of the receive ring: one write port, one registered read port.
module srxf_ring (
  input  logic               clk,
  input  srxf_pkg::ring_req_t req,
  output srxf_pkg::byte_t     rd_data
);
  import srxf_pkg::*;

  byte_t mem [RING_DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/srxf_checker.sv @@
// Port-level checks of the serial receive ring, bound to the top level.
module srxf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_read_valid,
  input logic [7:0] out_read_data,
  input logic       out_status_request,
  input logic       out_start_request,
  input logic       out_hold_request,
  input logic       out_reset_request,
  input logic       out_byte_dropped
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
      && $stable(out_read_valid) && $stable(out_byte_dropped))
    else $error("stalled result item changed");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_read_valid, out_status_request, out_start_request,
                            out_hold_request, out_reset_request, out_byte_dropped}))
    else $error("result item carries more than one outcome");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_data == 8'h00)
    else $error("read data not zero without a stored byte");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result item");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid && !in_stall) || $past(out_valid && out_stall))
    else $error("result item without an accepted item");

endmodule

bind serial_rx_fifo_realtime_filter_top srxf_checker u_srxf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_read_valid     (out_read_valid),
  .out_read_data      (out_read_data),
  .out_status_request (out_status_request),
  .out_start_request  (out_start_request),
  .out_hold_request   (out_hold_request),
  .out_reset_request  (out_reset_request),
  .out_byte_dropped   (out_byte_dropped)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the serial receive ring with realtime character intercept.
module tb_top;
  import srxf_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASES = 8;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct packed {
    logic  read_valid;
    byte_t read_data;
    logic  status_req;
    logic  start_req;
    logic  hold_req;
    logic  reset_req;
    logic  dropped;
  } out_item_t;

  typedef struct {
    logic [1:0] op;
    byte_t      rx;
    out_item_t  res;
  } awaited_t;

  class rx_ring_check;
    byte_t     ring [RING_DEPTH];
    idx_t      wr_pos;
    idx_t      rd_pos;
    byte_t     status_ch;
    byte_t     start_ch;
    byte_t     hold_ch;
    byte_t     reset_ch;
    awaited_t  awaited [$];
    int        errors;

    function new();
      wr_pos    = '0;
      rd_pos    = '0;
      status_ch = STATUS_CHAR_INIT;
      start_ch  = START_CHAR_INIT;
      hold_ch   = HOLD_CHAR_INIT;
      reset_ch  = RESET_CHAR_INIT;
      errors    = 0;
    endfunction

    function idx_t ring_advance(idx_t p);
      return (p == IDX_LAST) ? '0 : p + 1'b1;
    endfunction

    function void set_char(logic [1:0] which, byte_t v);
      case (which)
        REG_STATUS: status_ch = v;
        REG_START:  start_ch  = v;
        REG_HOLD:   hold_ch   = v;
        REG_RESET:  reset_ch  = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function string show(out_item_t r);
      return $sformatf("valid=%0b data=%02h st=%0b cs=%0b fh=%0b rs=%0b drop=%0b",
                       r.read_valid, r.read_data, r.status_req, r.start_req,
                       r.hold_req, r.reset_req, r.dropped);
    endfunction

    function void note_item(logic [1:0] op, byte_t b);
      awaited_t e;
      idx_t     nxt;
      e.op  = op;
      e.rx  = b;
      e.res = '0;
      case (op)
        OP_BYTE: begin
          if (b != LINE_FEED) begin
            if (b == status_ch) e.res.status_req = 1'b1;
            else if (b == start_ch) e.res.start_req = 1'b1;
            else if (b == hold_ch) e.res.hold_req = 1'b1;
            else if (b == reset_ch) e.res.reset_req = 1'b1;
            else begin
              nxt = ring_advance(wr_pos);
              if (nxt != rd_pos) begin
                ring[wr_pos] = b;
                wr_pos = nxt;
              end else begin
                e.res.dropped = 1'b1;
              end
            end
          end
        end
        OP_READ: begin
          if (wr_pos != rd_pos) begin
            e.res.read_valid = 1'b1;
            e.res.read_data  = ring[rd_pos];
            rd_pos = ring_advance(rd_pos);
          end
        end
        OP_FLUSH: rd_pos = wr_pos;
        default: ;
      endcase
      awaited.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      awaited_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %s", show(got));
        return;
      end
      e = awaited.pop_front();
      if (got !== e.res) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch for op %0d byte %02h", e.op, e.rx);
          $display("  expected %s", show(e.res));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_op = OP_BYTE;
  byte_t               in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_read_valid;
  byte_t               out_read_data;
  logic                out_status_request;
  logic                out_start_request;
  logic                out_hold_request;
  logic                out_reset_request;
  logic                out_byte_dropped;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  rx_ring_check  ring_chk = new();
  bit            calm = 1'b0;
  int unsigned   cycle_count = 0;

  mix_t phase_mix [PHASES] = '{MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_FILL,
                               MIX_EVEN, MIX_DRAIN, MIX_EVEN, MIX_FILL};
  int   phase_len [PHASES] = '{220, 150, 150, 200, 150, 130, 150, 100};

  serial_rx_fifo_realtime_filter_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_valid     (out_read_valid),
    .out_read_data      (out_read_data),
    .out_status_request (out_status_request),
    .out_start_request  (out_start_request),
    .out_hold_request   (out_hold_request),
    .out_reset_request  (out_reset_request),
    .out_byte_dropped   (out_byte_dropped),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL serial_rx_fifo_realtime_filter_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ring_chk.check_result('{out_read_valid, out_read_data, out_status_request,
                              out_start_request, out_hold_request,
                              out_reset_request, out_byte_dropped});
    end
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  function automatic int draw_gap();
    int g;
    g = 0;
    if (calm) return 0;
    while ($urandom_range(99) < 13) g++;
    return g;
  endfunction

  function automatic byte_t draw_rx_byte();
    int r;
    r = $urandom_range(99);
    if (r < 5) return LINE_FEED;
    if (r < 9) return ring_chk.status_ch;
    if (r < 13) return ring_chk.start_ch;
    if (r < 17) return ring_chk.hold_ch;
    if (r < 21) return ring_chk.reset_ch;
    return byte_t'($urandom_range(255));
  endfunction

  function automatic logic [1:0] draw_op(mix_t mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  return (r < 92) ? OP_BYTE : (r < 99) ? OP_READ : OP_SPARE;
      MIX_DRAIN: return (r < 25) ? OP_BYTE : (r < 90) ? OP_READ :
                        (r < 95) ? OP_FLUSH : OP_SPARE;
      default:   return (r < 50) ? OP_BYTE : (r < 88) ? OP_READ :
                        (r < 95) ? OP_FLUSH : OP_SPARE;
    endcase
  endfunction

  task automatic push_item(logic [1:0] op, byte_t b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    ring_chk.note_item(op, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ring_chk.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] which, byte_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({which, 2'b00});
    pwdata  <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ring_chk.set_char(which, v);
    @(posedge clk);
  endtask

  task automatic set_chars(byte_t s, byte_t c, byte_t h, byte_t r);
    drain();
    cfg_write(REG_STATUS, s);
    cfg_write(REG_START, c);
    cfg_write(REG_HOLD, h);
    cfg_write(REG_RESET, r);
  endtask

  initial begin
    int p;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(OP_READ, 8'hff);
    push_item(OP_SPARE, 8'hff);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hff);
    push_item(OP_BYTE, LINE_FEED);
    push_item(OP_BYTE, STATUS_CHAR_INIT);
    push_item(OP_BYTE, START_CHAR_INIT);
    push_item(OP_BYTE, HOLD_CHAR_INIT);
    push_item(OP_BYTE, RESET_CHAR_INIT);
    push_item(OP_BYTE, 8'h55);
    push_item(OP_READ, 8'h00);
    push_item(OP_READ, 8'h00);
    push_item(OP_READ, 8'h00);
    push_item(OP_READ, 8'h00);
    push_item(OP_BYTE, 8'haa);
    push_item(OP_FLUSH, 8'h00);
    push_item(OP_READ, 8'h00);

    set_chars(8'h41, 8'h41, LINE_FEED, 8'hff);
    push_item(OP_BYTE, 8'h41);
    push_item(OP_BYTE, LINE_FEED);
    push_item(OP_BYTE, 8'hff);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_READ, 8'h00);

    set_chars(8'h00, 8'hff, 8'h00, 8'hff);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hff);
    push_item(OP_READ, 8'h00);

    for (p = 0; p < PHASES; p++) begin
      if (p == 0)
        set_chars(STATUS_CHAR_INIT, START_CHAR_INIT, HOLD_CHAR_INIT, RESET_CHAR_INIT);
      else if (p == 3)
        set_chars(8'hff, 8'h00, 8'h80, 8'h7f);
      else
        set_chars(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                  byte_t'($urandom_range(255)), byte_t'($urandom_range(255)));
      calm = (p == 4);
      for (n = 0; n < phase_len[p]; n++) begin
        case (draw_op(phase_mix[p]))
          OP_BYTE:  push_item(OP_BYTE, draw_rx_byte());
          OP_READ:  push_item(OP_READ, byte_t'($urandom_range(255)));
          OP_FLUSH: push_item(OP_FLUSH, byte_t'($urandom_range(255)));
          default:  push_item(OP_SPARE, byte_t'($urandom_range(255)));
        endcase
        if ($urandom_range(199) == 0) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (ring_chk.errors == 0 && ring_chk.pending() == 0)
      $display("PASS serial_rx_fifo_realtime_filter_top");
    else
      $display("FAIL serial_rx_fifo_realtime_filter_top");
    $finish;
  end

endmodule
